>>> hdl/tmx_pkg.sv
// Shared types, constants and helpers of the thruster mixer.
package tmx_pkg;

	// Field widths of one command set and one motor set.
	localparam int CMD_W  = 16;
	localparam int IN_W   = 6 * CMD_W;
	localparam int OUT_W  = 80;
	localparam int M14_W  = 12;
	localparam int M24_W  = 11;
	localparam int M56_W  = 17;

	// Q16 gains, rounded to nearest.
	localparam int ROLL_GAIN  = 29308;
	localparam int PITCH_GAIN = 58617;
	localparam int TURN_GAIN  = 19661;

	// Mapping and clamp limits.
	localparam int MAP_SPAN = 4000;
	localparam int MAP_OFS  = 2000;
	localparam int PWM_LOW  = 1000;
	localparam int PWM_HIGH = 2000;
	localparam int PWM_W    = 11;

	// Internal widths.
	localparam int PROD_W = 33;
	localparam int SUM_W  = 35;
	localparam int D_W    = 32;
	localparam int N_W    = 28;
	localparam int Q_W    = 12;
	localparam int DEN_W  = 16;
	localparam int SPAN_W = 17;

	// Stage of the output register: four mixing stages, one per quotient bit, one output.
	localparam int OUT_STAGE = 4 + Q_W + 1;

	// Register indexes of the configuration port.
	localparam logic REG_LIFT_LO = 1'b0;
	localparam logic REG_LIFT_HI = 1'b1;

	typedef enum logic [1:0] {
		MODE_DIV = 2'd0,
		MODE_MAX = 2'd1,
		MODE_MIN = 2'd2
	} mode_t;

	typedef struct packed {
		logic signed [CMD_W-1:0]  tmin;
		logic signed [CMD_W-1:0]  tmax;
		logic signed [SPAN_W-1:0] span;
	} cfg_t;

	typedef struct packed {
		mode_t          mode;
		logic [N_W-1:0] num;
	} lane_t;

	// Clamped PWM value from the quotient of the thrust mapping.
	function automatic logic [PWM_W-1:0] pwm_of(input mode_t mode, input logic [Q_W-1:0] quo);
		logic [PWM_W-1:0] res;
		res = PWM_W'(PWM_LOW);
		unique case (mode)
			MODE_DIV: begin
				if (quo >= Q_W'(PWM_LOW + MAP_OFS))
					res = PWM_W'(quo - Q_W'(MAP_OFS));
			end
			MODE_MAX: res = PWM_W'(PWM_HIGH);
			MODE_MIN: res = PWM_W'(PWM_LOW);
			default:  res = PWM_W'(PWM_LOW);
		endcase
		return res;
	endfunction

endpackage

>>> hdl/tmx_mix.sv
// Mixing front end: gains, mixed sums, range clamp and scaling to the divider numerator.
module tmx_mix (
	input  logic                                  clk,
	input  logic                                  ce,
	input  tmx_pkg::cfg_t                         cfg,
	input  logic [tmx_pkg::IN_W-1:0]              in_data,
	output tmx_pkg::lane_t [3:0]                  lane,
	output logic signed [tmx_pkg::M56_W-1:0]      motor5,
	output logic signed [tmx_pkg::M56_W-1:0]      motor6
);

	localparam int CW = tmx_pkg::CMD_W;
	localparam int PW = tmx_pkg::PROD_W;
	localparam int SW = tmx_pkg::SUM_W;
	localparam int MW = tmx_pkg::M56_W;

	logic signed [CW-1:0] base_s1, yaw_s1, fwd_s1;
	logic signed [PW-1:0] roll_s1, pitch_s1, turn_s1;
	logic signed [SW-1:0] sum_s2 [4];
	logic signed [SW-1:0] f5_s2, f6_s2;
	tmx_pkg::mode_t       mode_s3 [4];
	logic [tmx_pkg::D_W-1:0] d_s3 [4];
	logic signed [MW-1:0] m5_s3, m6_s3;
	tmx_pkg::lane_t [3:0] lane_s4;
	logic signed [MW-1:0] m5_s4, m6_s4;

	logic signed [SW-1:0] base_x, yaw_x, fwd_x, roll_x, pitch_x, turn_x;
	logic signed [SW-1:0] hi_x, lo_x;
	logic signed [SW-1:0] f5_t, f6_t;
	logic signed [SW-1:0] diff [4];
	tmx_pkg::mode_t       mode_c [4];

	// Stage 1: the three gain products.
	always_ff @(posedge clk) begin
		if (ce) begin
			base_s1  <= $signed(in_data[0*CW +: CW]);
			roll_s1  <= PW'($signed(in_data[1*CW +: CW])) * PW'(tmx_pkg::ROLL_GAIN);
			pitch_s1 <= PW'($signed(in_data[2*CW +: CW])) * PW'(tmx_pkg::PITCH_GAIN);
			yaw_s1   <= $signed(in_data[3*CW +: CW]);
			fwd_s1   <= $signed(in_data[4*CW +: CW]);
			turn_s1  <= PW'($signed(in_data[5*CW +: CW])) * PW'(tmx_pkg::TURN_GAIN);
		end
	end

	// Stage 2: Q16 sums for the four vertical and two horizontal thrusters.
	assign base_x  = SW'($signed({base_s1, 16'h0000}));
	assign yaw_x   = SW'($signed({yaw_s1, 16'h0000}));
	assign fwd_x   = SW'($signed({fwd_s1, 16'h0000}));
	assign roll_x  = SW'(roll_s1);
	assign pitch_x = SW'(pitch_s1);
	assign turn_x  = SW'(turn_s1);

	always_ff @(posedge clk) begin
		if (ce) begin
			sum_s2[0] <= base_x + roll_x + pitch_x + yaw_x;
			sum_s2[1] <= base_x + roll_x - pitch_x - yaw_x;
			sum_s2[2] <= base_x - roll_x - pitch_x + yaw_x;
			sum_s2[3] <= base_x - roll_x + pitch_x - yaw_x;
			f5_s2     <= fwd_x + turn_x;
			f6_s2     <= fwd_x - turn_x;
		end
	end

	// Stage 3: range classification, offset from the lower bound, truncation of the
	// horizontal sums toward zero and negation of the motor 5 value.
	assign hi_x = SW'($signed({cfg.tmax, 16'h0000}));
	assign lo_x = SW'($signed({cfg.tmin, 16'h0000}));
	assign f5_t = f5_s2 + (f5_s2[SW-1] ? SW'(65535) : SW'(0));
	assign f6_t = f6_s2 + (f6_s2[SW-1] ? SW'(65535) : SW'(0));

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			diff[i] = sum_s2[i] - lo_x;
			if (cfg.span == '0)
				mode_c[i] = tmx_pkg::MODE_MIN;
			else if (sum_s2[i] > hi_x)
				mode_c[i] = tmx_pkg::MODE_MAX;
			else if (cfg.span[tmx_pkg::SPAN_W-1] || sum_s2[i] < lo_x)
				mode_c[i] = tmx_pkg::MODE_MIN;
			else
				mode_c[i] = tmx_pkg::MODE_DIV;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 4; i++) begin
				mode_s3[i] <= mode_c[i];
				d_s3[i]    <= diff[i][tmx_pkg::D_W-1:0];
			end
			m5_s3 <= MW'(0) - f5_t[16 +: MW];
			m6_s3 <= f6_t[16 +: MW];
		end
	end

	// Stage 4: numerator floor(d * 4000 / 65536) for the divider.
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 4; i++) begin
				lane_s4[i].mode <= mode_s3[i];
				lane_s4[i].num  <= tmx_pkg::N_W'((44'(d_s3[i]) * 44'(tmx_pkg::MAP_SPAN)) >> 16);
			end
			m5_s4 <= m5_s3;
			m6_s4 <= m6_s3;
		end
	end

	assign lane   = lane_s4;
	assign motor5 = m5_s4;
	assign motor6 = m6_s4;

endmodule

>>> hdl/tmx_div.sv
// Pipelined restoring divider: one quotient bit per stage, mode carried alongside.
module tmx_div (
	input  logic                         clk,
	input  logic                         ce,
	input  tmx_pkg::lane_t               lane,
	input  logic [tmx_pkg::DEN_W-1:0]    den,
	output logic [tmx_pkg::Q_W-1:0]      quo,
	output tmx_pkg::mode_t               mode
);

	localparam int QW = tmx_pkg::Q_W;
	localparam int NW = tmx_pkg::N_W;

	logic [NW-1:0]  rem_s  [QW-1];
	logic [QW-1:0]  quo_s  [QW];
	tmx_pkg::mode_t mode_s [QW];

	for (genvar j = 0; j < QW; j++) begin : g_stage
		localparam int K = QW - 1 - j;
		logic [NW-1:0]  rem_in;
		logic [QW-1:0]  quo_in;
		tmx_pkg::mode_t mode_in;
		logic [NW-1:0]  dsh;
		logic           ge;

		if (j == 0) begin : g_first
			assign rem_in  = lane.num;
			assign quo_in  = '0;
			assign mode_in = lane.mode;
		end else begin : g_next
			assign rem_in  = rem_s[j-1];
			assign quo_in  = quo_s[j-1];
			assign mode_in = mode_s[j-1];
		end

		assign dsh = NW'(den) << K;
		assign ge  = rem_in >= dsh;

		always_ff @(posedge clk) begin
			if (ce) begin
				quo_s[j]  <= quo_in | (ge ? (QW'(1) << K) : QW'(0));
				mode_s[j] <= mode_in;
			end
		end

		if (j < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (ce)
					rem_s[j] <= ge ? rem_in - dsh : rem_in;
			end
		end
	end

	assign quo  = quo_s[QW-1];
	assign mode = mode_s[QW-1];

endmodule

>>> hdl/thruster_mixer_unit.sv
// Top level of the thruster mixer: ports, configuration, skid stage, output register.
//
// Usage: one command set (base thrust, roll, pitch, yaw, forward, turn) enters as a
// transaction on the s_ channel and produces exactly one motor set on the m_ channel.
// Results leave in the order the commands arrived.
//
// Throughput is one transaction per cycle while m_tready stays high. A result passes
// through four mixing stages (gains, sums, clamp and offset, scaling), twelve divider
// stages that resolve one bit each of the thrust mapping quotient, and the output
// register.
//
// Configuration: cfg_we with cfg_idx 0 writes the lower thrust limit, index 1 the upper.
// Write only while the block is empty. The span upper - lower is kept in a register so
// that the divider sees a ready denominator.
//
// Reset (arst_n low) empties the pipeline and the skid stage and restores the lower
// thrust limit to 0 and the upper one to 1000. There is no clearing pass.
//
// When the receiver holds m_tready low with a result waiting, the whole pipeline holds.
// One more transaction is then still taken into the skid stage; s_tready comes straight
// from a register, so the two sides are not joined by a combinational path.
module thruster_mixer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// s_tdata: base_thrust, roll_cmd, pitch_cmd, yaw_cmd, forward_cmd, turn_cmd
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tmx_pkg::IN_W-1:0]      s_tdata,
	// m_tdata: motor1, motor2, motor3, motor4, motor5, motor6
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tmx_pkg::OUT_W-1:0]     m_tdata,
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [tmx_pkg::CMD_W-1:0]     cfg_data
);

	localparam int LAST = tmx_pkg::OUT_STAGE;
	localparam int DLY  = tmx_pkg::Q_W;
	localparam int MW   = tmx_pkg::M56_W;

	logic signed [tmx_pkg::CMD_W-1:0]  lift_lo_q, lift_hi_q;
	logic signed [tmx_pkg::SPAN_W-1:0] span_q;
	tmx_pkg::cfg_t                     cfg;

	logic                      skid_vld_q;
	logic [tmx_pkg::IN_W-1:0]  skid_data_q;
	logic                      ce;
	logic                      in_vld;
	logic [tmx_pkg::IN_W-1:0]  in_data;
	logic [LAST:1]             vld_s;

	tmx_pkg::lane_t [3:0]      lane_s4;
	logic signed [MW-1:0]      m5_s4, m6_s4;
	logic signed [MW-1:0]      m5_sd [DLY];
	logic signed [MW-1:0]      m6_sd [DLY];
	logic [tmx_pkg::Q_W-1:0]   quo [4];
	tmx_pkg::mode_t            mode [4];
	logic [tmx_pkg::PWM_W-1:0] pwm [4];

	logic [tmx_pkg::M14_W-1:0] motor1_s17, motor3_s17;
	logic [tmx_pkg::M24_W-1:0] motor2_s17, motor4_s17;
	logic [MW-1:0]             motor5_s17, motor6_s17;

	// Configuration registers; the span follows every write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lift_lo_q <= '0;
			lift_hi_q <= 16'sd1000;
			span_q    <= 17'sd1000;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				tmx_pkg::REG_LIFT_LO: begin
					lift_lo_q <= $signed(cfg_data);
					span_q    <= 17'(lift_hi_q) - 17'($signed(cfg_data));
				end
				tmx_pkg::REG_LIFT_HI: begin
					lift_hi_q <= $signed(cfg_data);
					span_q    <= 17'($signed(cfg_data)) - 17'(lift_lo_q);
				end
			endcase
		end
	end

	assign cfg.tmin = lift_lo_q;
	assign cfg.tmax = lift_hi_q;
	assign cfg.span = span_q;

	// The pipeline advances unless a finished result is waiting on a stalled receiver.
	assign ce       = !vld_s[LAST] || m_tready;
	assign s_tready = !skid_vld_q;
	assign in_vld   = skid_vld_q || s_tvalid;
	assign in_data  = skid_vld_q ? skid_data_q : s_tdata;

	// A transaction taken during a stall parks in the skid stage until the pipeline moves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			skid_vld_q <= 1'b0;
		else if (ce)
			skid_vld_q <= 1'b0;
		else if (s_tvalid && s_tready)
			skid_vld_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (!ce && s_tvalid && s_tready)
			skid_data_q <= s_tdata;
	end

	// Valid bits travel with the data through every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ce) begin
			vld_s[1] <= in_vld;
			for (int i = 2; i <= LAST; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	tmx_mix u_mix (
		.clk     (clk),
		.ce      (ce),
		.cfg     (cfg),
		.in_data (in_data),
		.lane    (lane_s4),
		.motor5  (m5_s4),
		.motor6  (m6_s4)
	);

	for (genvar l = 0; l < 4; l++) begin : g_lane
		tmx_div u_div (
			.clk  (clk),
			.ce   (ce),
			.lane (lane_s4[l]),
			.den  (span_q[tmx_pkg::DEN_W-1:0]),
			.quo  (quo[l]),
			.mode (mode[l])
		);
		assign pwm[l] = tmx_pkg::pwm_of(mode[l], quo[l]);
	end

	// The horizontal thruster values wait alongside the divider stages.
	always_ff @(posedge clk) begin
		if (ce) begin
			m5_sd[0] <= m5_s4;
			m6_sd[0] <= m6_s4;
			for (int i = 1; i < DLY; i++) begin
				m5_sd[i] <= m5_sd[i-1];
				m6_sd[i] <= m6_sd[i-1];
			end
		end
	end

	// Output register: clamp to the PWM range and negate motors one and three.
	always_ff @(posedge clk) begin
		if (ce) begin
			motor1_s17 <= tmx_pkg::M14_W'(0) - tmx_pkg::M14_W'(pwm[0]);
			motor2_s17 <= pwm[1];
			motor3_s17 <= tmx_pkg::M14_W'(0) - tmx_pkg::M14_W'(pwm[2]);
			motor4_s17 <= pwm[3];
			motor5_s17 <= m5_sd[DLY-1];
			motor6_s17 <= m6_sd[DLY-1];
		end
	end

	assign m_tvalid = vld_s[LAST];
	assign m_tdata  = {motor6_s17, motor5_s17, motor4_s17, motor3_s17, motor2_s17, motor1_s17};

endmodule

>>> hdl/tmx_checker.sv
// Port-level checker of the thruster mixer and its bind to the top level.
module tmx_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [tmx_pkg::OUT_W-1:0] m_tdata
);

	// A stalled result holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	// Negated vertical thrusters stay within -2000..-1000.
	a_neg_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[11:0]) >= -2000 && $signed(m_tdata[11:0]) <= -1000
			&& $signed(m_tdata[34:23]) >= -2000 && $signed(m_tdata[34:23]) <= -1000)
		else $error("motor1 or motor3 out of range");

	// Positive vertical thrusters stay within 1000..2000.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[22:12] >= 11'd1000 && m_tdata[22:12] <= 11'd2000
			&& m_tdata[45:35] >= 11'd1000 && m_tdata[45:35] <= 11'd2000)
		else $error("motor2 or motor4 out of range");

	// The pipeline comes out of reset empty.
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result present right after reset");

endmodule

bind thruster_mixer_unit tmx_checker u_tmx_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
